### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, character codes and utf-8 encoding for the json string
// unescape block
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned LEN_W = 24;
  localparam logic [LEN_W-1:0] MAX_BYTES_RESET = 24'h010000;

  // input word: one byte of json text or the end mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [3:0] error_code;
    logic       last;
  } out_t;

  // results of one input byte, at most one code point
  typedef struct packed {
    out_t [3:0] word;
    logic [2:0] count;
  } step_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_OPEN     = 4'd1,
    ERR_CONTROL     = 4'd2,
    ERR_BAD_ESCAPE  = 4'd3,
    ERR_BAD_UNICODE = 4'd4,
    ERR_UNPAIRED_HI = 4'd5,
    ERR_BAD_LOW     = 4'd6,
    ERR_UNPAIRED_LO = 4'd7,
    ERR_UNTERM      = 4'd8,
    ERR_LENGTH      = 4'd9
  } err_t;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CC_BS     = 8'h08;
  localparam logic [7:0] CC_FF     = 8'h0C;
  localparam logic [7:0] CC_LF     = 8'h0A;
  localparam logic [7:0] CC_CR     = 8'h0D;
  localparam logic [7:0] CC_TAB    = 8'h09;

  // surrogate ranges
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;

  // utf-8 lead and continuation marks
  localparam logic [7:0] U8_CONT  = 8'h80;
  localparam logic [7:0] U8_LEAD2 = 8'hC0;
  localparam logic [7:0] U8_LEAD3 = 8'hE0;
  localparam logic [7:0] U8_LEAD4 = 8'hF0;

  typedef struct packed {
    logic [3:0][7:0] byte_seq;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = 4'(c[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // byte_seq[0] goes out first
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t e;
    e.byte_seq = '0;
    if (cp <= 21'h00007F) begin
      e.byte_seq[0] = cp[7:0];
      e.len = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      e.byte_seq[0] = U8_LEAD2 | {3'b000, cp[10:6]};
      e.byte_seq[1] = U8_CONT | {2'b00, cp[5:0]};
      e.len = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      e.byte_seq[0] = U8_LEAD3 | {4'b0000, cp[15:12]};
      e.byte_seq[1] = U8_CONT | {2'b00, cp[11:6]};
      e.byte_seq[2] = U8_CONT | {2'b00, cp[5:0]};
      e.len = 3'd3;
    end else begin
      e.byte_seq[0] = U8_LEAD4 | {5'b00000, cp[20:18]};
      e.byte_seq[1] = U8_CONT | {2'b00, cp[17:12]};
      e.byte_seq[2] = U8_CONT | {2'b00, cp[11:6]};
      e.byte_seq[3] = U8_CONT | {2'b00, cp[5:0]};
      e.len = 3'd4;
    end
    return e;
  endfunction

endpackage

### src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// per-byte decoder: parse state registers and the result words one byte makes
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  jsu_pkg::in_t                 item,
  input  logic [jsu_pkg::LEN_W-1:0]    max_bytes,
  output jsu_pkg::step_t               step
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_PAIR_BS,
    PH_PAIR_U,
    PH_HEX2
  } phase_t;

  typedef enum logic [2:0] {
    RQ_NONE,
    RQ_FAIL,
    RQ_BYTE,
    RQ_CP,
    RQ_DONE
  } req_t;

  phase_t                      phase, phase_next;
  logic [15:0]                 hex_value, hex_value_next;
  logic [1:0]                  hex_digits_seen, hex_digits_seen_next;
  logic [9:0]                  high_surrogate, high_surrogate_next;
  logic [jsu_pkg::LEN_W-1:0]   bytes_written, bytes_written_next;

  always_comb begin
    req_t                      req;
    jsu_pkg::err_t             code;
    logic [7:0]                b;
    logic                      eoi;
    logic [7:0]                plain;
    logic [20:0]               cp;
    logic [15:0]               hv;
    jsu_pkg::hex_t             hd;
    jsu_pkg::err_t             hex_err;
    jsu_pkg::utf8_t            enc;
    logic [jsu_pkg::LEN_W-1:0] room;

    phase_next           = phase;
    hex_value_next       = hex_value;
    hex_digits_seen_next = hex_digits_seen;
    high_surrogate_next  = high_surrogate;
    bytes_written_next   = bytes_written;
    step                 = '0;

    req   = RQ_NONE;
    code  = jsu_pkg::ERR_NONE;
    plain = 8'd0;
    cp    = 21'd0;
    b     = item.in_byte;
    eoi   = item.end_of_input;
    hd    = jsu_pkg::hex_digit(b);
    hv    = {hex_value[11:0], hd.value};
    hex_err = (phase == PH_HEX1) ? jsu_pkg::ERR_BAD_UNICODE : jsu_pkg::ERR_BAD_LOW;

    case (phase)
      PH_BODY: begin
        if (eoi) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_UNTERM;
        end else if (b == jsu_pkg::CH_QUOTE) begin
          req = RQ_DONE;
        end else if (b < jsu_pkg::CH_SPACE) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_CONTROL;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          req = RQ_BYTE; plain = b;
        end
      end
      PH_ESC: begin
        if (eoi) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_BAD_ESCAPE;
        end else begin
          case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
              req = RQ_BYTE; plain = b;
            end
            jsu_pkg::CH_B: begin req = RQ_BYTE; plain = jsu_pkg::CC_BS;  end
            jsu_pkg::CH_F: begin req = RQ_BYTE; plain = jsu_pkg::CC_FF;  end
            jsu_pkg::CH_N: begin req = RQ_BYTE; plain = jsu_pkg::CC_LF;  end
            jsu_pkg::CH_R: begin req = RQ_BYTE; plain = jsu_pkg::CC_CR;  end
            jsu_pkg::CH_T: begin req = RQ_BYTE; plain = jsu_pkg::CC_TAB; end
            jsu_pkg::CH_U: begin
              hex_value_next       = 16'd0;
              hex_digits_seen_next = 2'd0;
              phase_next           = PH_HEX1;
            end
            default: begin
              req = RQ_FAIL; code = jsu_pkg::ERR_BAD_ESCAPE;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (eoi || !hd.ok) begin
          req = RQ_FAIL; code = hex_err;
        end else begin
          hex_value_next = hv;
          if (hex_digits_seen != 2'd3) begin
            hex_digits_seen_next = 2'(hex_digits_seen + 2'd1);
          end else begin
            hex_digits_seen_next = 2'd0;
            if (phase == PH_HEX1) begin
              if (hv >= jsu_pkg::HI_SUR_MIN && hv <= jsu_pkg::HI_SUR_MAX) begin
                // offset from the base is the low ten bits
                high_surrogate_next = hv[9:0];
                phase_next          = PH_PAIR_BS;
              end else if (hv >= jsu_pkg::LO_SUR_MIN && hv <= jsu_pkg::LO_SUR_MAX) begin
                req = RQ_FAIL; code = jsu_pkg::ERR_UNPAIRED_LO;
              end else begin
                req = RQ_CP; cp = {5'd0, hv};
              end
            end else begin
              if (hv < jsu_pkg::LO_SUR_MIN || hv > jsu_pkg::LO_SUR_MAX) begin
                req = RQ_FAIL; code = jsu_pkg::ERR_BAD_LOW;
              end else begin
                req = RQ_CP;
                cp  = 21'(jsu_pkg::SUPP_BASE + {1'b0, high_surrogate, hv[9:0]});
              end
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (eoi || b != jsu_pkg::CH_BSLASH) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_UNPAIRED_HI;
        end else begin
          phase_next = PH_PAIR_U;
        end
      end
      PH_PAIR_U: begin
        if (eoi || b != jsu_pkg::CH_U) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_UNPAIRED_HI;
        end else begin
          hex_value_next       = 16'd0;
          hex_digits_seen_next = 2'd0;
          phase_next           = PH_HEX2;
        end
      end
      default: begin
        // waiting for an opening quote; unused codes land here too
        if (eoi || b != jsu_pkg::CH_QUOTE) begin
          req = RQ_FAIL; code = jsu_pkg::ERR_NO_OPEN;
        end else begin
          bytes_written_next   = '0;
          hex_value_next       = 16'd0;
          hex_digits_seen_next = 2'd0;
          high_surrogate_next  = 10'd0;
          phase_next           = PH_BODY;
        end
      end
    endcase

    // length checks, then build the result words
    enc  = jsu_pkg::utf8_encode(cp);
    room = max_bytes - bytes_written;
    if (req == RQ_BYTE && bytes_written >= max_bytes) begin
      req = RQ_FAIL; code = jsu_pkg::ERR_LENGTH;
    end
    if (req == RQ_CP &&
        (bytes_written > max_bytes || jsu_pkg::LEN_W'(enc.len) > room)) begin
      req = RQ_FAIL; code = jsu_pkg::ERR_LENGTH;
    end

    case (req)
      RQ_FAIL: begin
        step.word[0].out_kind   = jsu_pkg::KIND_ERROR;
        step.word[0].error_code = code;
        step.word[0].last       = 1'b1;
        step.count              = 3'd1;
        phase_next              = PH_WAIT;
      end
      RQ_DONE: begin
        step.word[0].out_kind = jsu_pkg::KIND_DONE;
        step.word[0].last     = 1'b1;
        step.count            = 3'd1;
        phase_next            = PH_WAIT;
      end
      RQ_BYTE: begin
        step.word[0].out_byte = plain;
        step.word[0].out_kind = jsu_pkg::KIND_BYTE;
        step.word[0].last     = 1'b1;
        step.count            = 3'd1;
        bytes_written_next    = bytes_written + 1'b1;
        phase_next            = PH_BODY;
      end
      RQ_CP: begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < enc.len) begin
            step.word[i].out_byte = enc.byte_seq[i];
            step.word[i].out_kind = jsu_pkg::KIND_BYTE;
            step.word[i].last     = (3'(i + 1) == enc.len);
          end
        end
        step.count         = enc.len;
        bytes_written_next = bytes_written + jsu_pkg::LEN_W'(enc.len);
        phase_next         = PH_BODY;
      end
      default: begin
        step.count = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      hex_value       <= 16'd0;
      hex_digits_seen <= 2'd0;
      high_surrogate  <= 10'd0;
      bytes_written   <= '0;
    end else if (take) begin
      phase           <= phase_next;
      hex_value       <= hex_value_next;
      hex_digits_seen <= hex_digits_seen_next;
      high_surrogate  <= high_surrogate_next;
      bytes_written   <= bytes_written_next;
    end
  end

endmodule

### src/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// streaming decoder for one quoted json string: escapes and \u code units
// come out as utf-8 bytes, then a completion or an error word
// ----------------------------------------------------------------------------
//
//  channel | signals                        | word
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | text byte or end mark
//  out     | out_valid, out_ready, out_data | decoded byte, done or error
//  cfg     | cfg_valid, cfg_ready, cfg_data | max_string_bytes (24 bits)
//
//  each input byte is decoded in the cycle it is taken; its words (0 to 4)
//  are loaded into the result buffer at that edge; while out_ready is high
//  they leave one per cycle and a byte that yields at most one word sustains
//  one byte per cycle; a \u escape yielding more words holds the input until its
//  last leaves; a stalled output holds the input whenever the buffer holds a word
//  synchronous reset: waiting for an opening quote, buffer empty, limit 65536
//
module json_string_unescape_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  jsu_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output jsu_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [jsu_pkg::LEN_W-1:0]  cfg_data
);

  // length limit register
  logic [jsu_pkg::LEN_W-1:0] max_bytes;

  // decoder outputs for the byte on the input port
  jsu_pkg::step_t step;
  logic           in_fire;
  logic           out_fire;

  // result buffer: words of the last accepted byte, read from head
  jsu_pkg::out_t [3:0] words;
  logic [1:0]          head;
  logic [2:0]          count;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // take a new byte once the buffer is empty or its final word leaves now
  assign in_ready  = (count == 3'd0) || (count == 3'd1 && out_ready);
  assign out_valid = (count != 3'd0);
  assign out_data  = words[head];

  // configuration is taken at any time
  assign cfg_ready = 1'b1;

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (in_fire),
    .item      (in_data),
    .max_bytes (max_bytes),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= jsu_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= cfg_data;
    end
  end

  // buffer payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      words <= step.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 3'd0;
    end else if (in_fire) begin
      head  <= 2'd0;
      count <= step.count;
    end else if (out_fire) begin
      head  <= 2'(head + 2'd1);
      count <= 3'(count - 3'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // checks

  // a byte that yields results shows a word on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && step.count != 3'd0) |=> out_valid)
    else $error("decoded results not presented");

  // the word marked last empties the buffer when taken
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_data.last && !in_fire) |=> !out_valid)
    else $error("words remain after last");

  // only decoded bytes are followed by more words of the same byte
  a_nonlast_is_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (out_data.out_kind == jsu_pkg::KIND_BYTE))
    else $error("status word not marked last");

  // buffer never holds more than one code point
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (count <= 3'd4))
    else $error("result count out of range");

endmodule

### test/json_string_unescape_top_test.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top_test
// drives quoted json text into the unescape block one word at a time and
// compares every result word against a cycle-free decoder model kept here
// ----------------------------------------------------------------------------
module json_string_unescape_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 380;  // random text words after the directed part
  localparam int PHASES      = 7;    // limit settings visited during the run
  localparam int DRAIN       = 12;   // quiet cycles before a limit write and at the end
  localparam int QUIET_LIMIT = 500;  // cycles without any handshake before giving up

  // decoder position inside the quoted string
  typedef enum logic [2:0] {
    SC_WAIT,
    SC_BODY,
    SC_ESC,
    SC_HEX1,
    SC_PAIR_BS,
    SC_PAIR_U,
    SC_HEX2
  } scan_t;

  // decoder model and store of result words still owed by the block
  class unescape_checker;
    jsu_pkg::out_t due_words[$];
    int            faults;
    logic [23:0]   limit;
    scan_t         scan;
    logic [15:0]   code_unit;
    logic [1:0]    digits;
    logic [9:0]    high_bits;
    logic [23:0]   written;

    function new();
      faults    = 0;
      limit     = jsu_pkg::MAX_BYTES_RESET;
      scan      = SC_WAIT;
      code_unit = '0;
      digits    = '0;
      high_bits = '0;
      written   = '0;
    endfunction

    function void set_limit(logic [23:0] v);
      limit = v;
    endfunction

    function void queue_word(logic [7:0] b, jsu_pkg::kind_t k, jsu_pkg::err_t e, logic l);
      jsu_pkg::out_t w;
      w.out_byte   = b;
      w.out_kind   = k;
      w.error_code = e;
      w.last       = l;
      due_words = {due_words, w};
    endfunction

    function void abort(jsu_pkg::err_t e);
      queue_word(8'h00, jsu_pkg::KIND_ERROR, e, 1'b1);
      scan = SC_WAIT;
    endfunction

    function void put_byte(logic [7:0] b);
      if (written >= limit) begin
        abort(jsu_pkg::ERR_LENGTH);
      end else begin
        queue_word(b, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 1'b1);
        written++;
        scan = SC_BODY;
      end
    endfunction

    // whole code point or nothing
    function void put_code_point(logic [20:0] cp);
      logic [7:0] seq [4];
      int n;
      seq[1] = '0;
      seq[2] = '0;
      seq[3] = '0;
      if (cp < 21'h80) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n = 3;
      end else begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n = 4;
      end
      if (32'(written) + n > 32'(limit)) begin
        abort(jsu_pkg::ERR_LENGTH);
      end else begin
        for (int i = 0; i < n; i++)
          queue_word(seq[i], jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, i == n - 1);
        written += 24'(n);
        scan = SC_BODY;
      end
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
    endfunction

    // four hex digits collected
    function void close_unit();
      if (scan == SC_HEX1) begin
        if (code_unit >= jsu_pkg::HI_SUR_MIN && code_unit <= jsu_pkg::HI_SUR_MAX) begin
          high_bits = code_unit[9:0];
          scan = SC_PAIR_BS;
        end else if (code_unit >= jsu_pkg::LO_SUR_MIN &&
                     code_unit <= jsu_pkg::LO_SUR_MAX) begin
          abort(jsu_pkg::ERR_UNPAIRED_LO);
        end else begin
          put_code_point({5'd0, code_unit});
        end
      end else if (code_unit < jsu_pkg::LO_SUR_MIN || code_unit > jsu_pkg::LO_SUR_MAX) begin
        abort(jsu_pkg::ERR_BAD_LOW);
      end else begin
        put_code_point(jsu_pkg::SUPP_BASE + {1'b0, high_bits, code_unit[9:0]});
      end
    endfunction

    // one accepted text word
    function void take_text(jsu_pkg::in_t w);
      logic [7:0] c;
      logic fin;
      int d;
      jsu_pkg::err_t hex_err;
      c   = w.in_byte;
      fin = w.end_of_input;
      case (scan)
        SC_BODY: begin
          if (fin) abort(jsu_pkg::ERR_UNTERM);
          else if (c == jsu_pkg::CH_QUOTE) begin
            queue_word(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE, 1'b1);
            scan = SC_WAIT;
          end else if (c < jsu_pkg::CH_SPACE) abort(jsu_pkg::ERR_CONTROL);
          else if (c == jsu_pkg::CH_BSLASH) scan = SC_ESC;
          else put_byte(c);
        end
        SC_ESC: begin
          if (fin) abort(jsu_pkg::ERR_BAD_ESCAPE);
          else begin
            case (c)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: put_byte(c);
              jsu_pkg::CH_B: put_byte(jsu_pkg::CC_BS);
              jsu_pkg::CH_F: put_byte(jsu_pkg::CC_FF);
              jsu_pkg::CH_N: put_byte(jsu_pkg::CC_LF);
              jsu_pkg::CH_R: put_byte(jsu_pkg::CC_CR);
              jsu_pkg::CH_T: put_byte(jsu_pkg::CC_TAB);
              jsu_pkg::CH_U: begin
                code_unit = '0;
                digits = '0;
                scan = SC_HEX1;
              end
              default: abort(jsu_pkg::ERR_BAD_ESCAPE);
            endcase
          end
        end
        SC_HEX1, SC_HEX2: begin
          hex_err = (scan == SC_HEX1) ? jsu_pkg::ERR_BAD_UNICODE : jsu_pkg::ERR_BAD_LOW;
          d = fin ? -1 : nibble(c);
          if (d < 0) abort(hex_err);
          else begin
            code_unit = {code_unit[11:0], 4'(d)};
            if (digits != 2'd3) digits++;
            else begin
              digits = '0;
              close_unit();
            end
          end
        end
        SC_PAIR_BS: begin
          if (fin || c != jsu_pkg::CH_BSLASH) abort(jsu_pkg::ERR_UNPAIRED_HI);
          else scan = SC_PAIR_U;
        end
        SC_PAIR_U: begin
          if (fin || c != jsu_pkg::CH_U) abort(jsu_pkg::ERR_UNPAIRED_HI);
          else begin
            code_unit = '0;
            digits = '0;
            scan = SC_HEX2;
          end
        end
        default: begin
          if (fin || c != jsu_pkg::CH_QUOTE) abort(jsu_pkg::ERR_NO_OPEN);
          else begin
            written = '0;
            code_unit = '0;
            digits = '0;
            high_bits = '0;
            scan = SC_BODY;
          end
        end
      endcase
    endfunction

    // one accepted result word against the oldest one owed
    function void match_word(jsu_pkg::out_t got);
      jsu_pkg::out_t want;
      if (due_words.size() == 0) begin
        $error("unexpected word: out_byte %h out_kind %0d error_code %0d last %b",
               got.out_byte, got.out_kind, got.error_code, got.last);
        faults++;
        return;
      end
      want = due_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        faults++;
      end
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
        faults++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  jsu_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  jsu_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [23:0]   cfg_data = '0;

  unescape_checker board;
  jsu_pkg::in_t text_q[$];    // words built but not yet offered
  int  burst_left = 0;
  int  sent = 0;
  int  ready_mode = 0;
  int  mode_left = 0;

  json_string_unescape_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // text builders: each appends words to text_q
  // ---------------------------------------------------------------------------

  function void put_char(logic [7:0] c);
    jsu_pkg::in_t w;
    w.in_byte = c;
    w.end_of_input = 1'b0;
    text_q = {text_q, w};
  endfunction

  // end mark carries a random byte, which the block must ignore
  function void put_end();
    jsu_pkg::in_t w;
    w.in_byte = 8'($urandom_range(0, 255));
    w.end_of_input = 1'b1;
    text_q = {text_q, w};
  endfunction

  // a-f come out in either case at random
  function logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
  endfunction

  function void put_digits(logic [15:0] u, int n);
    for (int i = 0; i < n; i++) put_char(hex_char(u[15 - 4 * i -: 4]));
  endfunction

  // backslash u and four digits
  function void put_unit(logic [15:0] u);
    put_char(jsu_pkg::CH_BSLASH);
    put_char(jsu_pkg::CH_U);
    put_digits(u, 4);
  endfunction

  function logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66));
    return c;
  endfunction

  // basic plane value outside the surrogate block, biased toward the
  // one, two and three byte utf-8 boundaries
  function logic [15:0] rand_bmp();
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0: u = 16'h0000;
          1: u = 16'h007F;
          2: u = 16'h0080;
          3: u = 16'h07FF;
          4: u = 16'h0800;
          5: u = 16'hD7FF;
          6: u = 16'hE000;
          default: u = 16'hFFFF;
        endcase
      end
      1, 2, 3: u = 16'($urandom_range(0, 16'h007F));
      4, 5: u = 16'($urandom_range(16'h0080, 16'h07FF));
      default: begin
        do u = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (u >= jsu_pkg::HI_SUR_MIN && u <= jsu_pkg::LO_SUR_MAX);
      end
    endcase
    return u;
  endfunction

  function logic [15:0] rand_high();
    case ($urandom_range(0, 5))
      0: return jsu_pkg::HI_SUR_MIN;
      1: return jsu_pkg::HI_SUR_MAX;
      default: return 16'($urandom_range(jsu_pkg::HI_SUR_MIN, jsu_pkg::HI_SUR_MAX));
    endcase
  endfunction

  function logic [15:0] rand_low();
    case ($urandom_range(0, 5))
      0: return jsu_pkg::LO_SUR_MIN;
      1: return jsu_pkg::LO_SUR_MAX;
      default: return 16'($urandom_range(jsu_pkg::LO_SUR_MIN, jsu_pkg::LO_SUR_MAX));
    endcase
  endfunction

  // one well-formed piece of string body
  function void put_piece();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      do c = 8'($urandom_range(32, 255));
      while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
      put_char(c);
    end else if (r < 55) begin
      put_char(jsu_pkg::CH_BSLASH);
      case ($urandom_range(0, 7))
        0: put_char(jsu_pkg::CH_QUOTE);
        1: put_char(jsu_pkg::CH_BSLASH);
        2: put_char(jsu_pkg::CH_SLASH);
        3: put_char(jsu_pkg::CH_B);
        4: put_char(jsu_pkg::CH_F);
        5: put_char(jsu_pkg::CH_N);
        6: put_char(jsu_pkg::CH_R);
        default: put_char(jsu_pkg::CH_T);
      endcase
    end else if (r < 85) begin
      put_unit(rand_bmp());
    end else begin
      put_unit(rand_high());
      put_unit(rand_low());
    end
  endfunction

  // one way of breaking the string, each one failing it with an error
  function void put_fault();
    logic [7:0] c;
    logic [15:0] u;
    case ($urandom_range(0, 11))
      0: put_char(8'($urandom_range(0, 31)));        // raw control byte
      1: begin                                         // unknown escape letter
        do c = 8'($urandom_range(0, 255));
        while (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                         jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
                         jsu_pkg::CH_T, jsu_pkg::CH_U});
        put_char(jsu_pkg::CH_BSLASH);
        put_char(c);
      end
      2: begin                                         // non-hex inside \u
        put_char(jsu_pkg::CH_BSLASH);
        put_char(jsu_pkg::CH_U);
        put_digits(rand_bmp(), $urandom_range(0, 3));
        put_char(non_hex());
      end
      3: put_end();                                    // text ends inside the string
      4: begin                                         // text ends after a backslash
        put_char(jsu_pkg::CH_BSLASH);
        put_end();
      end
      5: begin                                         // text ends among hex digits
        put_char(jsu_pkg::CH_BSLASH);
        put_char(jsu_pkg::CH_U);
        put_digits(rand_bmp(), $urandom_range(0, 3));
        put_end();
      end
      6: begin                                         // high half, then no backslash
        put_unit(rand_high());
        do c = 8'($urandom_range(0, 255));
        while (c == jsu_pkg::CH_BSLASH);
        put_char(c);
      end
      7: begin                                         // high half, backslash, no u
        put_unit(rand_high());
        put_char(jsu_pkg::CH_BSLASH);
        if ($urandom_range(0, 3) == 0) put_end();
        else begin
          do c = 8'($urandom_range(0, 255));
          while (c == jsu_pkg::CH_U);
          put_char(c);
        end
      end
      8: begin                                         // second unit not a low half
        put_unit(rand_high());
        do u = 16'($urandom_range(0, 16'hFFFF));
        while (u >= jsu_pkg::LO_SUR_MIN && u <= jsu_pkg::LO_SUR_MAX);
        if ($urandom_range(0, 3) == 0) u = rand_high();
        put_unit(u);
      end
      9: begin                                         // second unit cut short
        put_unit(rand_high());
        put_char(jsu_pkg::CH_BSLASH);
        put_char(jsu_pkg::CH_U);
        put_digits(rand_low(), $urandom_range(0, 3));
        if ($urandom_range(0, 1)) put_char(non_hex());
        else put_end();
      end
      10: put_unit(rand_low());                        // low half on its own
      default: begin                                   // text ends after a high half
        put_unit(rand_high());
        put_end();
      end
    endcase
  endfunction

  // one string, mostly well formed, or a little noise between strings
  function void build_sequence();
    jsu_pkg::in_t w;
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) begin
        w.in_byte = 8'($urandom_range(0, 255));
        w.end_of_input = ($urandom_range(0, 7) == 0);
        text_q = {text_q, w};
      end
    end else begin
      put_char(jsu_pkg::CH_QUOTE);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      repeat (n) put_piece();
      if (r < 30) put_fault();
      else put_char(jsu_pkg::CH_QUOTE);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // offer every queued word; bursts of random length with random gaps
  task automatic send_text();
    jsu_pkg::in_t w;
    while (text_q.size() > 0) begin
      w = text_q.pop_front();
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        // now and then a long burst with no gaps at all
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk);
      while (!in_ready);
      board.take_text(w);
      burst_left--;
      sent++;
    end
  endtask

  // stop offering text, let every owed word arrive, then give the block
  // time to finish words that yield no result
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    board.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: check on each handshake, ready follows modes of its own
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.match_word(out_data);
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 80);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;                            // never stall
      1: out_ready <= $urandom_range(0, 1);            // coin flip
      2: out_ready <= ($urandom_range(0, 7) != 0);     // rare single stalls
      default: out_ready <= (mode_left % 16 == 0);     // long stall runs
    endcase
  end

  // watchdog: too long without any word moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int target;
    logic [23:0] lim;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset limit
    put_char(8'h78);             // stray byte while waiting for a quote
    put_end();                   // end of text with no string open
    put_char(jsu_pkg::CH_QUOTE);
    put_char(jsu_pkg::CH_SPACE); // lowest plain byte
    put_char(8'hFF);             // highest plain byte
    put_char(8'h1F);             // control byte inside the string
    put_char(jsu_pkg::CH_QUOTE);
    put_unit(16'hD83D);          // surrogate pair giving a four byte sequence
    put_unit(16'hDE00);
    put_unit(16'hDC00);          // low half with no high half before it
    put_char(jsu_pkg::CH_QUOTE);
    put_end();                   // string never closed
    send_text();

    base = sent;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // limits visited: reset value first, then both extremes and small ones
        case (p)
          1: lim = 24'd0;
          2: lim = 24'd1;
          3: lim = 24'd3;
          4: lim = 24'hFFFFFF;
          5: lim = 24'($urandom_range(2, 24));
          default: lim = jsu_pkg::MAX_BYTES_RESET;
        endcase
        settle();
        write_limit(lim);
      end
      target = base + (ITEMS * (p + 1)) / PHASES;
      while (sent < target) begin
        build_sequence();
        send_text();
      end
    end

    settle();
    if (board.faults == 0 && board.due_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### json_string_unescape_top.f
src/jsu_pkg.sv
src/jsu_decode.sv
src/json_string_unescape_top.sv
test/json_string_unescape_top_test.sv
